### rtl/tcgr_pkg.sv
// ----------------------------------------------------------------------------
// tcgr_pkg: shared types and constants of the text console glyph renderer
// Field widths, register indexes, command codes, clamp helpers and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tcgr_pkg;

  localparam int SIDE_W     = 13;
  localparam int CODE_W     = 8;
  localparam int LROW_W     = 5;
  localparam int BITS_W     = 8;
  localparam int OFF_W      = 24;
  localparam int LINES_W    = 6;
  localparam int GW_W       = 4;
  localparam int GH_W       = 6;
  localparam int X_W        = 13;
  localparam int Y_W        = 12;
  localparam int ROW_CNT_W  = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int DEF_GLYPH_COUNT     = 256;
  localparam int DEF_MAX_GLYPH_ROWS  = 32;
  localparam int DEF_MAX_SCREEN_SIDE = 4096;

  localparam int GW_MAX   = 8;
  localparam int GH_MAX   = 32;
  localparam int LINE_GAP = 0;

  localparam logic [SIDE_W-1:0] RST_SCREEN_WIDTH  = 13'd640;
  localparam logic [SIDE_W-1:0] RST_SCREEN_HEIGHT = 13'd480;
  localparam logic [GW_W-1:0]   RST_GLYPH_WIDTH   = 4'd8;
  localparam logic [GH_W-1:0]   RST_GLYPH_HEIGHT  = 6'd16;

  localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  localparam logic KIND_ROW    = 1'b0;
  localparam logic KIND_SCROLL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT  = 2'd3;

  typedef struct packed {
    logic take;          // latch the accepted item
    logic newline_step;  // x to zero, y down one line unless a scroll is due
    logic emit_scroll;   // load a scroll request into the output register
    logic scroll_last;   // last flag of that scroll request
    logic mul;           // form width*y
    logic add;           // form row start offset, fetch row 0
    logic emit_row;      // load one glyph row write, fetch the next row
  } tcgr_cmd_t;

  typedef struct packed {
    logic is_load;
    logic is_newline;
    logic need_wrap;
    logic need_scroll;
    logic slot_free;
    logic last_row;
  } tcgr_stat_t;

  // zero reads as one, values above hi saturate
  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v,
                                                   input logic [SIDE_W-1:0] hi);
    logic [SIDE_W-1:0] r;
    if (v == '0) r = SIDE_W'(1);
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  function automatic logic [GW_W-1:0] clamp_gw(input logic [GW_W-1:0] v);
    logic [GW_W-1:0] r;
    if (v == '0) r = GW_W'(1);
    else if (v > GW_W'(GW_MAX)) r = GW_W'(GW_MAX);
    else r = v;
    return r;
  endfunction

  function automatic logic [GH_W-1:0] clamp_gh(input logic [GH_W-1:0] v);
    logic [GH_W-1:0] r;
    if (v == '0) r = GH_W'(1);
    else if (v > GH_W'(GH_MAX)) r = GH_W'(GH_MAX);
    else r = v;
    return r;
  endfunction

  function automatic logic [BITS_W-1:0] row_mask(input logic [GW_W-1:0] gw);
    logic [BITS_W:0] m;
    m = ((BITS_W+1)'(1) << gw) - (BITS_W+1)'(1);
    return m[BITS_W-1:0];
  endfunction

endpackage

### rtl/tcgr_in_if.sv
// ----------------------------------------------------------------------------
// tcgr_in_if: input channel of the glyph renderer
// Valid/ready channel carrying one command beat: put character or font load.
// ----------------------------------------------------------------------------
interface tcgr_in_if
  import tcgr_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [CODE_W-1:0] char_code;
  logic [LROW_W-1:0] load_row;
  logic [BITS_W-1:0] load_bits;

  modport source (output valid, command, char_code, load_row, load_bits, input ready);
  modport sink   (input valid, command, char_code, load_row, load_bits, output ready);
endinterface

### rtl/tcgr_out_if.sv
// ----------------------------------------------------------------------------
// tcgr_out_if: result channel of the glyph renderer
// Valid/ready channel carrying glyph row writes and scroll requests.
// ----------------------------------------------------------------------------
interface tcgr_out_if
  import tcgr_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [OFF_W-1:0]   pixel_offset;
  logic [BITS_W-1:0]  row_bitmap;
  logic [LINES_W-1:0] scroll_lines;
  logic               last;

  modport source (output valid, kind, pixel_offset, row_bitmap, scroll_lines, last,
                  input ready);
  modport sink   (input valid, kind, pixel_offset, row_bitmap, scroll_lines, last,
                  output ready);
endinterface

### rtl/text_console_glyph_renderer.sv
// ----------------------------------------------------------------------------
// text_console_glyph_renderer: pixel text console front end
// Turns character beats into glyph row writes and scroll requests.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one beat per item: a font load (command=1) writes one row
//   byte into the glyph store; a put (command=0) draws char_code at the
//   cursor, code 10 being newline. out_ch carries the results, last set on
//   the final result of each item. cfg_we/cfg_index/cfg_wdata set screen and
//   glyph size; write them only while the block is idle.
//   Sequence: loads and newlines without scroll finish in the idle state. A
//   character steps through width*y, then the row start offset, then one
//   glyph row per cycle while the output register is free, paced by the
//   single read port of the glyph store; a wrap that scrolls first emits a
//   scroll request. A newline that scrolls emits one scroll request.
//   A single output register parts the channels: the next item is accepted
//   while the last result still waits. A stalled receiver holds the row
//   sequence in place. Reset clears cursor and registers to their defaults;
//   the glyph store is not cleared and must be loaded before drawing.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer
  import tcgr_pkg::*;
#(
  parameter int GLYPH_COUNT     = DEF_GLYPH_COUNT,
  parameter int MAX_GLYPH_ROWS  = DEF_MAX_GLYPH_ROWS,
  parameter int MAX_SCREEN_SIDE = DEF_MAX_SCREEN_SIDE
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  tcgr_in_if.sink               in_ch,
  tcgr_out_if.source            out_ch
);

  tcgr_cmd_t  cmd;
  tcgr_stat_t stat;
  logic       in_ready;

  tcgr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcgr_datapath #(
    .GLYPH_COUNT     (GLYPH_COUNT),
    .MAX_GLYPH_ROWS  (MAX_GLYPH_ROWS),
    .MAX_SCREEN_SIDE (MAX_SCREEN_SIDE)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_command       (in_ch.command),
    .in_char_code     (in_ch.char_code),
    .in_load_row      (in_ch.load_row),
    .in_load_bits     (in_ch.load_bits),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_kind         (out_ch.kind),
    .out_pixel_offset (out_ch.pixel_offset),
    .out_row_bitmap   (out_ch.row_bitmap),
    .out_scroll_lines (out_ch.scroll_lines),
    .out_last         (out_ch.last)
  );

  assign in_ch.ready = in_ready;

endmodule

### rtl/tcgr_datapath.sv
// ----------------------------------------------------------------------------
// tcgr_datapath: cursor, registers, glyph store and output register
// Holds the configuration, the pixel cursor and the font memory, forms row
// offsets incrementally and drives the result channel.
// ----------------------------------------------------------------------------
module tcgr_datapath
  import tcgr_pkg::*;
#(
  parameter int GLYPH_COUNT     = DEF_GLYPH_COUNT,
  parameter int MAX_GLYPH_ROWS  = DEF_MAX_GLYPH_ROWS,
  parameter int MAX_SCREEN_SIDE = DEF_MAX_SCREEN_SIDE
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_command,
  input  logic [CODE_W-1:0]     in_char_code,
  input  logic [LROW_W-1:0]     in_load_row,
  input  logic [BITS_W-1:0]     in_load_bits,
  input  tcgr_cmd_t             cmd,
  output tcgr_stat_t            stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_kind,
  output logic [OFF_W-1:0]      out_pixel_offset,
  output logic [BITS_W-1:0]     out_row_bitmap,
  output logic [LINES_W-1:0]    out_scroll_lines,
  output logic                  out_last
);

  localparam int GIW   = $clog2(GLYPH_COUNT);
  localparam int RIW   = (MAX_GLYPH_ROWS > 1) ? $clog2(MAX_GLYPH_ROWS) : 1;
  localparam int DEPTH = GLYPH_COUNT * MAX_GLYPH_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_SCREEN_SIDE);

  logic [SIDE_W-1:0]     sw_r, sh_r;
  logic [GW_W-1:0]       gw_r;
  logic [GH_W-1:0]       gh_r;
  logic [X_W-1:0]        x_r;
  logic [Y_W-1:0]        y_r;
  logic [CODE_W-1:0]     code_r;
  logic [OFF_W-1:0]      prod_r, off_r;
  logic [ROW_CNT_W-1:0]  row_r;
  logic [BITS_W-1:0]     rd_data_r;
  logic                  rd_zero_r;
  logic                  out_valid_r, out_kind_r, out_last_r;
  logic [OFF_W-1:0]      out_off_r;
  logic [BITS_W-1:0]     out_bits_r;
  logic [LINES_W-1:0]    out_lines_r;

  logic [BITS_W-1:0]     mem [DEPTH];

  logic [GH_W:0]           adv;
  logic [SIDE_W+Y_W-1:0]   prod_full;
  logic [ROW_CNT_W-1:0]    rd_row, wr_row;
  logic                    code_ok, rd_ok, rd_en, wr_en;
  logic [AW-1:0]           rd_addr, wr_addr;
  logic [GIW-1:0]          rd_gidx, wr_gidx;

  assign adv       = (GH_W+1)'(gh_r) + (GH_W+1)'(LINE_GAP);
  assign prod_full = sw_r * y_r;

  assign stat.is_load     = (in_command == CMD_LOAD);
  assign stat.is_newline  = (in_char_code == NEWLINE_CODE);
  assign stat.need_wrap   = ((X_W+1)'(x_r) + (X_W+1)'(gw_r)) > (X_W+1)'(sw_r);
  assign stat.need_scroll = ((Y_W+2)'(y_r) + (Y_W+2)'(adv) + (Y_W+2)'(gh_r))
                            > (Y_W+2)'(sh_r);
  assign stat.slot_free   = !out_valid_r || out_ready;
  assign stat.last_row    = (row_r == gh_r - GH_W'(1));

  // font store read side: row 0 on setup, the next row on each emitted row
  assign rd_en   = cmd.add || cmd.emit_row;
  assign rd_row  = cmd.add ? '0 : row_r + ROW_CNT_W'(1);
  assign code_ok = (9'(code_r) < 9'(GLYPH_COUNT));
  assign rd_ok   = code_ok && (7'(rd_row) < 7'(MAX_GLYPH_ROWS));
  assign rd_gidx = code_r[GIW-1:0];
  assign rd_addr = AW'(AW'(rd_gidx) * AW'(MAX_GLYPH_ROWS)) + AW'(rd_row[RIW-1:0]);

  assign wr_row  = ROW_CNT_W'(in_load_row);
  assign wr_gidx = in_char_code[GIW-1:0];
  assign wr_addr = AW'(AW'(wr_gidx) * AW'(MAX_GLYPH_ROWS)) + AW'(wr_row[RIW-1:0]);
  assign wr_en   = cmd.take && stat.is_load
                   && (9'(in_char_code) < 9'(GLYPH_COUNT))
                   && (7'(in_load_row) < 7'(MAX_GLYPH_ROWS));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_load_bits;
    end
    if (rd_en && rd_ok) begin
      rd_data_r <= mem[rd_addr];
    end
    if (rd_en) begin
      rd_zero_r <= !rd_ok;
    end
  end

  // configuration, stored already clamped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= clamp_side(RST_SCREEN_WIDTH, SIDE_MAX);
      sh_r <= clamp_side(RST_SCREEN_HEIGHT, SIDE_MAX);
      gw_r <= RST_GLYPH_WIDTH;
      gh_r <= RST_GLYPH_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  sw_r <= clamp_side(cfg_wdata, SIDE_MAX);
        REG_SCREEN_HEIGHT: sh_r <= clamp_side(cfg_wdata, SIDE_MAX);
        REG_GLYPH_WIDTH:   gw_r <= clamp_gw(cfg_wdata[GW_W-1:0]);
        REG_GLYPH_HEIGHT:  gh_r <= clamp_gh(cfg_wdata[GH_W-1:0]);
      endcase
    end
  end

  // cursor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
    end else if (cmd.newline_step) begin
      x_r <= '0;
      if (!stat.need_scroll) begin
        y_r <= y_r + Y_W'(adv);
      end
    end else if (cmd.emit_row && stat.last_row) begin
      x_r <= x_r + X_W'(gw_r);
    end
  end

  // row offsets: width*y + x once, then add width per row
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      code_r <= in_char_code;
    end
    if (cmd.mul) begin
      prod_r <= prod_full[OFF_W-1:0];
    end
    if (cmd.add) begin
      off_r <= prod_r + OFF_W'(x_r);
      row_r <= '0;
    end else if (cmd.emit_row) begin
      off_r <= off_r + OFF_W'(sw_r);
      row_r <= row_r + ROW_CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_scroll || cmd.emit_row) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_scroll) begin
      out_kind_r  <= KIND_SCROLL;
      out_off_r   <= '0;
      out_bits_r  <= '0;
      out_lines_r <= LINES_W'(adv);
      out_last_r  <= cmd.scroll_last;
    end else if (cmd.emit_row) begin
      out_kind_r  <= KIND_ROW;
      out_off_r   <= off_r;
      out_bits_r  <= rd_zero_r ? '0 : (rd_data_r & row_mask(gw_r));
      out_lines_r <= '0;
      out_last_r  <= stat.last_row;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_pixel_offset = out_off_r;
  assign out_row_bitmap   = out_bits_r;
  assign out_scroll_lines = out_lines_r;
  assign out_last         = out_last_r;

endmodule

### rtl/tcgr_ctrl.sv
// ----------------------------------------------------------------------------
// tcgr_ctrl: sequencing state machine of the glyph renderer
// Accepts one item at a time, orders scroll request, offset setup and the
// per-row emission, and waits on the output register when it is full.
// ----------------------------------------------------------------------------
module tcgr_ctrl
  import tcgr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  tcgr_stat_t stat,
  output tcgr_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCROLL = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_ADD    = 3'd3;
  localparam logic [2:0] ST_ROWS   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       last_r, last_nxt;

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          priority if (stat.is_load) begin
            state_nxt = ST_IDLE;
          end else if (stat.is_newline) begin
            cmd.newline_step = 1'b1;
            if (stat.need_scroll) begin
              state_nxt = ST_SCROLL;
              last_nxt  = 1'b1;
            end
          end else if (stat.need_wrap) begin
            cmd.newline_step = 1'b1;
            if (stat.need_scroll) begin
              state_nxt = ST_SCROLL;
              last_nxt  = 1'b0;
            end else begin
              state_nxt = ST_MUL;
            end
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_SCROLL: begin
        if (stat.slot_free) begin
          cmd.emit_scroll = 1'b1;
          cmd.scroll_last = last_r;
          state_nxt       = last_r ? ST_IDLE : ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = ST_ROWS;
      end
      ST_ROWS: begin
        if (stat.slot_free) begin
          cmd.emit_row = 1'b1;
          if (stat.last_row) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

  a_rows_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROWS && stat.slot_free && stat.last_row) |=> (state_r == ST_IDLE))
    else $error("row sequence did not return to idle after the last row");

  a_wrap_scroll_draws: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCROLL && stat.slot_free && !last_r) |=> (state_r == ST_MUL))
    else $error("wrap scroll was not followed by the glyph rows");

  a_no_accept_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(cmd.emit_row || cmd.emit_scroll))
    else $error("item accepted while a result is being loaded");

  a_plain_put_draws: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !stat.is_load && !stat.is_newline && !stat.need_wrap)
      |=> (state_r == ST_MUL))
    else $error("plain character did not start the row sequence");

endmodule

### bench/text_console_glyph_renderer_checker.sv
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_checker: result predictor and comparator
// Watches the register port and both channels, keeps its own cursor, font
// rows and geometry, and compares every result beat with the oldest predicted
// operation. Hands its failure count and open operation count to the bench.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_checker
  import tcgr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  tcgr_in_if                    in_mon,
  tcgr_out_if                   out_mon,
  output int unsigned           fault_count,
  output int unsigned           open_ops
);

  localparam int STORE_DEPTH = DEF_GLYPH_COUNT * DEF_MAX_GLYPH_ROWS;

  typedef struct packed {
    logic               kind;
    logic [OFF_W-1:0]   pixel_offset;
    logic [BITS_W-1:0]  row_bitmap;
    logic [LINES_W-1:0] scroll_lines;
    logic               last;
  } console_op_t;

  logic [SIDE_W-1:0] scr_w;
  logic [SIDE_W-1:0] scr_h;
  logic [GW_W-1:0]   gl_w;
  logic [GH_W-1:0]   gl_h;
  logic [X_W-1:0]    cur_x;
  logic [Y_W-1:0]    cur_y;
  logic [BITS_W-1:0] font_rows [STORE_DEPTH];
  console_op_t       console_ops_q [$];

  function automatic int unsigned saturate(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // x back to zero; move down a line, or ask the blitter to scroll
  task automatic line_feed(input int unsigned gh, input int unsigned sh, input logic is_last);
    console_op_t op;
    if (cur_y + gh + LINE_GAP + gh > sh) begin
      op.kind         = KIND_SCROLL;
      op.pixel_offset = '0;
      op.row_bitmap   = '0;
      op.scroll_lines = LINES_W'(gh + LINE_GAP);
      op.last         = is_last;
      console_ops_q.push_back(op);
    end else begin
      cur_y = Y_W'(cur_y + gh + LINE_GAP);
    end
    cur_x = '0;
  endtask

  task automatic render_item(input logic cmd, input logic [CODE_W-1:0] code,
                             input logic [LROW_W-1:0] lrow, input logic [BITS_W-1:0] lbits);
    int unsigned       sw;
    int unsigned       sh;
    int unsigned       gw;
    int unsigned       gh;
    logic [BITS_W-1:0] mask;
    console_op_t       op;
    sw   = saturate(scr_w, DEF_MAX_SCREEN_SIDE);
    sh   = saturate(scr_h, DEF_MAX_SCREEN_SIDE);
    gw   = saturate(gl_w, GW_MAX);
    gh   = saturate(gl_h, GH_MAX);
    mask = BITS_W'((32'd1 << gw) - 32'd1);
    if (cmd == CMD_LOAD) begin
      if (code < DEF_GLYPH_COUNT && lrow < DEF_MAX_GLYPH_ROWS)
        font_rows[code * DEF_MAX_GLYPH_ROWS + lrow] = lbits;
    end else if (code == NEWLINE_CODE) begin
      line_feed(gh, sh, 1'b1);
    end else begin
      if (cur_x + gw > sw) line_feed(gh, sh, 1'b0);
      for (int i = 0; i < gh; i++) begin
        op.kind         = KIND_ROW;
        op.pixel_offset = OFF_W'(sw * (cur_y + i) + cur_x);
        op.row_bitmap   = '0;
        if (code < DEF_GLYPH_COUNT && i < DEF_MAX_GLYPH_ROWS)
          op.row_bitmap = font_rows[code * DEF_MAX_GLYPH_ROWS + i] & mask;
        op.scroll_lines = '0;
        op.last         = (i + 1 == gh);
        console_ops_q.push_back(op);
      end
      cur_x = X_W'(cur_x + gw);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk) begin
    console_op_t want;
    if (!rst_n) begin
      scr_w       = RST_SCREEN_WIDTH;
      scr_h       = RST_SCREEN_HEIGHT;
      gl_w        = RST_GLYPH_WIDTH;
      gl_h        = RST_GLYPH_HEIGHT;
      cur_x       = '0;
      cur_y       = '0;
      fault_count = 0;
      console_ops_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SCREEN_WIDTH:  scr_w = cfg_wdata[SIDE_W-1:0];
          REG_SCREEN_HEIGHT: scr_h = cfg_wdata[SIDE_W-1:0];
          REG_GLYPH_WIDTH:   gl_w  = cfg_wdata[GW_W-1:0];
          REG_GLYPH_HEIGHT:  gl_h  = cfg_wdata[GH_W-1:0];
          default: ;
        endcase
      end
      // results leave before the item accepted on the same edge can add any
      if (out_mon.valid && out_mon.ready) begin
        if (console_ops_q.size() == 0) begin
          $error("result beat with no operation outstanding");
          fault_count++;
        end else begin
          want = console_ops_q.pop_front();
          check_field("kind", want.kind, out_mon.kind);
          check_field("pixel_offset", want.pixel_offset, out_mon.pixel_offset);
          check_field("row_bitmap", want.row_bitmap, out_mon.row_bitmap);
          check_field("scroll_lines", want.scroll_lines, out_mon.scroll_lines);
          check_field("last", want.last, out_mon.last);
        end
      end
      if (in_mon.valid && in_mon.ready)
        render_item(in_mon.command, in_mon.char_code, in_mon.load_row, in_mon.load_bits);
    end
    open_ops = console_ops_q.size();
  end

endmodule

### bench/text_console_glyph_renderer_tb.sv
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_tb: bench top of the glyph renderer
// Drives font loads, characters and newlines over several screen and glyph
// geometries, with random idling on both channels, and reports the verdict
// from the checker's failure count.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_tb;
  import tcgr_pkg::*;

  localparam int HOLDOFF        = GH_MAX + 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 16;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int unsigned           fault_count;
  int unsigned           open_ops;
  int unsigned           send_idle_pct = 0;
  int unsigned           recv_stall_pct = 0;
  int unsigned           draw_rows = RST_GLYPH_HEIGHT;
  bit                    glyph_loaded [DEF_GLYPH_COUNT][DEF_MAX_GLYPH_ROWS];

  tcgr_in_if  in_ch ();
  tcgr_out_if out_ch ();

  text_console_glyph_renderer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  text_console_glyph_renderer_checker op_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fault_count (fault_count),
    .open_ops    (open_ops)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;  recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 45; recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;  recv_stall_pct = 45;
      end
      default: begin
        send_idle_pct = 30; recv_stall_pct = 30;
      end
    endcase
  endtask

  // leave valid high on return so back-to-back beats need no second assignment
  task automatic send_beat(input logic cmd, input logic [CODE_W-1:0] code,
                           input logic [LROW_W-1:0] lrow, input logic [BITS_W-1:0] lbits);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.char_code <= code;
    in_ch.load_row  <= lrow;
    in_ch.load_bits <= lbits;
    if (cmd == CMD_LOAD) glyph_loaded[code][lrow] = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // load any missing row of the glyph before drawing it
  task automatic put_char(input logic [CODE_W-1:0] code);
    if (code != NEWLINE_CODE)
      for (int r = 0; r < draw_rows; r++)
        if (!glyph_loaded[code][r])
          send_beat(CMD_LOAD, code, LROW_W'(r), BITS_W'($urandom));
    send_beat(CMD_PUT, code, LROW_W'($urandom), BITS_W'($urandom));
  endtask

  // drop valid, drain all results, then let an unseen newline or load finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (open_ops != 0) @(posedge clk);
    repeat (HOLDOFF) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic apply_geometry(input int unsigned sw, input int unsigned sh,
                                input int unsigned gw, input int unsigned gh);
    settle();
    write_reg(REG_SCREEN_WIDTH, CFG_DATA_W'(sw));
    write_reg(REG_SCREEN_HEIGHT, CFG_DATA_W'(sh));
    write_reg(REG_GLYPH_WIDTH, CFG_DATA_W'(gw));
    write_reg(REG_GLYPH_HEIGHT, CFG_DATA_W'(gh));
    cfg_we    <= 1'b0;
    draw_rows = (gh == 0) ? 1 : (gh > GH_MAX) ? GH_MAX : gh;
  endtask

  task automatic random_phase(input int unsigned sw, input int unsigned sh,
                              input int unsigned gw, input int unsigned gh);
    logic [CODE_W-1:0] pool [6];
    int unsigned       pick;
    pool = '{8'd0, 8'd255, 8'd65, 8'd128, 8'd127, 8'd33};
    apply_geometry(sw, sh, gw, gh);
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      set_idling(idle_mode_t'((k / 4) % 4));
      pick = $urandom_range(99);
      if (pick < 12)
        send_beat(CMD_LOAD, CODE_W'($urandom), LROW_W'($urandom), BITS_W'($urandom));
      else if (pick < 27)
        put_char(NEWLINE_CODE);
      else if ($urandom_range(15) == 0)
        put_char(CODE_W'($urandom));
      else
        put_char(pool[$urandom_range(5)]);
    end
  endtask

  initial begin : stimulus
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_SCREEN_WIDTH;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.command   = CMD_PUT;
    in_ch.char_code = '0;
    in_ch.load_row  = '0;
    in_ch.load_bits = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one-row glyphs on a short narrow screen; glyph width over range
    apply_geometry(20, 3, 15, 1);
    send_beat(CMD_LOAD, 8'd0, 5'd0, 8'hFF);
    send_beat(CMD_LOAD, 8'd255, 5'd0, 8'h00);
    send_beat(CMD_LOAD, 8'd65, 5'd0, 8'hA5);
    put_char(8'd0);
    put_char(8'd255);
    put_char(8'd65);
    put_char(8'd0);
    put_char(8'd255);
    put_char(8'd65);
    put_char(NEWLINE_CODE);
    put_char(8'd0);
    put_char(8'd255);
    put_char(8'd65);

    // all registers zero read as one
    apply_geometry(0, 0, 0, 0);
    send_beat(CMD_LOAD, 8'd255, 5'd31, 8'hFF);
    put_char(8'd255);
    put_char(8'd0);
    put_char(NEWLINE_CODE);

    // the cursor never moves up, so screens get taller phase by phase
    random_phase(9, 40, 8, 3);
    random_phase(100, 64, 5, 7);
    random_phase($urandom_range(300, 1), $urandom_range(200, 65),
                 $urandom_range(15, 0), $urandom_range(20, 0));
    random_phase(640, 480, 8, 16);
    random_phase(4096, 4096, 1, 12);

    // walk the cursor down to the last line of a full-size screen
    apply_geometry(8191, 8191, 8, 32);
    set_idling(IDLE_BOTH);
    repeat (130) put_char(NEWLINE_CODE);
    put_char(8'd200);
    apply_geometry(8191, 8191, 8, 1);
    repeat (40) put_char(NEWLINE_CODE);
    // tall glyph from the bottom line runs the offset past 2^24
    apply_geometry(8191, 8191, 8, 63);
    put_char(8'd200);
    put_char(8'd255);
    settle();

    if (fault_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
